### hw/rtl/command_tokenizer_defines.svh
// assertion macros for the command tokenizer
// expects aclk and aresetn in the scope where a macro is used

`ifndef COMMAND_TOKENIZER_DEFINES_SVH
`define COMMAND_TOKENIZER_DEFINES_SVH

// same-cycle implication, off during reset
`define CTOK_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define CTOK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/ctok_pkg.sv
// shared types and constants of the command tokenizer
// no dependencies

package ctok_pkg;

    localparam int BYTE_W = 8;
    localparam int IDX_W  = 11;

    // token limit ceiling; larger max_tokens values are clipped to it
    localparam logic [IDX_W-1:0] TOKEN_LIMIT_MAX = 11'd1024;
    localparam logic [IDX_W-1:0] MAX_TOKENS_RST  = 11'd1024;

    // character codes
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;

    // configuration register indexes
    localparam logic CFG_PLAIN_QUOTES = 1'b0;
    localparam logic CFG_MAX_TOKENS   = 1'b1;

    // result kinds
    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_END  = 2'd1,
        KIND_DONE = 2'd2
    } kind_t;

    // scanner modes, one-hot
    typedef enum logic [4:0] {
        MODE_SKIP    = 5'b00001,
        MODE_REGULAR = 5'b00010,
        MODE_QUOTED  = 5'b00100,
        MODE_COMMENT = 5'b01000,
        MODE_IGNORE  = 5'b10000
    } mode_t;

    // one queue entry: all results of one input beat
    typedef struct packed {
        logic              jv;     // judged byte gave a result
        logic              jend;   // that result is an end of token
        logic [BYTE_W-1:0] jbyte;
        logic [IDX_W-1:0]  jidx;
        logic              tend;   // open token closed by the line end
        logic              fin;    // line finished
        logic [IDX_W-1:0]  cnt;    // token count after the judged byte
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic             plain_quotes;
        logic [IDX_W-1:0] max_tokens;
    } cfg_t;

endpackage

### hw/rtl/command_tokenizer.sv
// command tokenizer top level: config registers, front end, entry queue, result sequencer
// depends on ctok_pkg, ctok_front, ctok_queue, ctok_back and command_tokenizer_defines.svh
//
// channel   dir  payload                                   meaning
// s_        in   tdata: in_byte[7:0]; tlast: end_of_line   one character of the line
// m_        out  tdata: out_byte[7:0], token_index[18:8]   token byte, token end or line done
//                tuser: out_kind[1:0]; tlast: last
// cfg_      in   cfg_addr 0 plain_quotes, 1 max_tokens     plain register write
//
// one character beat is taken per cycle while the entry queue has room
// a character beat yields at most one result beat; only a line end yields up to three,
// and the sequencer sends one per cycle while m_tready is high, so line ends drain slower than they arrive
// a result is registered in the entry queue, then in the output register, before m_tvalid shows it
// reset is synchronous, active low; no clearing pass, the block is ready right after
// a stalled m_ side fills the queue, then s_tready drops

`include "command_tokenizer_defines.svh"

module command_tokenizer
    import ctok_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4   // entries between front and back, at least 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    // character input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    input  logic        s_tlast,    // end_of_line
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [7:0] out_byte, [18:8] token_index, rest zero
    output logic [1:0]  m_tuser,    // [1:0] out_kind
    output logic        m_tlast,    // last result of the input beat
    // configuration
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [10:0] cfg_wdata
);

    // configuration registers
    cfg_t    cfg_reg, cfg_next;

    logic    s_accept;
    logic    q_push, q_pop;
    cmd_t    q_in, q_head;
    q_stat_t q_stat;

    kind_t             m_kind;
    logic [BYTE_W-1:0] m_byte;
    logic [IDX_W-1:0]  m_idx;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_PLAIN_QUOTES: cfg_next.plain_quotes = cfg_wdata[0];
                CFG_MAX_TOKENS:   cfg_next.max_tokens   = cfg_wdata;
                default:          cfg_next              = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.plain_quotes <= 1'b0;
            cfg_reg.max_tokens   <= MAX_TOKENS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // front takes a beat whenever the queue can take its entry
    assign s_tready = !q_stat.full;
    assign s_accept = s_tvalid && s_tready;

    ctok_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (s_accept),
        .in_byte   (s_tdata),
        .in_eol    (s_tlast),
        .cfg       (cfg_reg),
        .push      (q_push),
        .cmd       (q_in)
    );

    ctok_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    ctok_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (q_head),
        .empty     (q_stat.empty),
        .pop       (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (m_kind),
        .out_byte  (m_byte),
        .out_idx   (m_idx),
        .out_last  (m_tlast)
    );

    // pack result fields, lowest first
    assign m_tdata = {5'b0, m_idx, m_byte};
    assign m_tuser = m_kind;

    // checks
    `CTOK_ASSERT_NOW(a_no_overflow, q_push, !q_stat.full, "entry pushed into a full queue")
    `CTOK_ASSERT_NOW(a_done_is_last, m_tvalid && (m_kind == KIND_DONE), m_tlast, "line done not last")
    `CTOK_ASSERT_NOW(a_index_range, m_tvalid && (m_kind != KIND_DONE), m_idx < TOKEN_LIMIT_MAX, "token index beyond limit")
    `CTOK_ASSERT_NEXT(a_pop_marks_last, q_pop, m_tvalid && m_tlast, "entry retired without a last beat")

endmodule

### hw/rtl/ctok_front.sv
// front end: holds one byte of lookahead, runs the scan modes and builds queue entries
// depends on ctok_pkg

module ctok_front
    import ctok_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_accept,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              in_eol,
    input  cfg_t              cfg,
    output logic              push,
    output cmd_t              cmd
);

    mode_t             mode_reg, mode_next;
    logic [BYTE_W-1:0] held_byte_reg, held_byte_next;
    logic              held_valid_reg, held_valid_next;
    logic [IDX_W-1:0]  count_reg, count_next;

    logic              eol;
    logic [BYTE_W-1:0] c, nxt;
    logic [IDX_W-1:0]  limit, cur_idx;
    logic              is_quote, slash_pair, sep;
    mode_t             sk_mode, mode_j;
    logic              sk_inc, sk_emit;
    logic [IDX_W-1:0]  count_j;
    logic              swallow, jv, jend;
    logic [BYTE_W-1:0] jbyte;
    logic [IDX_W-1:0]  jidx;

    assign eol     = in_eol || (in_byte == '0);
    assign c       = held_byte_reg;
    assign nxt     = eol ? '0 : in_byte;
    assign limit   = (cfg.max_tokens > TOKEN_LIMIT_MAX) ? TOKEN_LIMIT_MAX : cfg.max_tokens;
    assign cur_idx = (count_reg == '0) ? '0 : count_reg - 1'b1;

    assign is_quote   = (c == CH_QUOTE) && !cfg.plain_quotes;
    assign slash_pair = (c == CH_SLASH) && ((nxt == CH_SLASH) || (nxt == CH_STAR));
    assign sep        = (c <= CH_SPACE) || is_quote || slash_pair;

    // whitespace-skipping decision, also used after a regular token closes
    always_comb begin
        sk_mode = MODE_SKIP;
        sk_inc  = 1'b0;
        sk_emit = 1'b0;
        if (c <= CH_SPACE) begin
            sk_mode = MODE_SKIP;
        end else if ((c == CH_SLASH) && (nxt == CH_SLASH)) begin
            sk_mode = MODE_IGNORE;
        end else if ((c == CH_SLASH) && (nxt == CH_STAR)) begin
            sk_mode = MODE_COMMENT;
        end else if (count_reg >= limit) begin
            sk_mode = MODE_IGNORE;
        end else begin
            sk_inc = 1'b1;
            if (is_quote) begin
                sk_mode = MODE_QUOTED;
            end else begin
                sk_mode = MODE_REGULAR;
                sk_emit = 1'b1;
            end
        end
    end

    // judge the held byte against the incoming one
    always_comb begin
        mode_j  = mode_reg;
        count_j = count_reg;
        swallow = 1'b0;
        jv      = 1'b0;
        jend    = 1'b0;
        jbyte   = c;
        jidx    = cur_idx;
        if (held_valid_reg) begin
            case (mode_reg)
                MODE_SKIP: begin
                    mode_j  = sk_mode;
                    count_j = count_reg + IDX_W'(sk_inc);
                    jv      = sk_emit;
                    jidx    = count_reg;
                end
                MODE_REGULAR: begin
                    jv = 1'b1;
                    if (sep) begin
                        // close the token, then treat the byte as in skip mode
                        jend    = 1'b1;
                        mode_j  = sk_mode;
                        count_j = count_reg + IDX_W'(sk_inc);
                    end
                end
                MODE_QUOTED: begin
                    jv = 1'b1;
                    if (c == CH_QUOTE) begin
                        jend   = 1'b1;
                        mode_j = MODE_SKIP;
                    end
                end
                MODE_COMMENT: begin
                    if ((c == CH_STAR) && (nxt == CH_SLASH)) begin
                        mode_j  = MODE_SKIP;
                        swallow = 1'b1;
                    end
                end
                MODE_IGNORE: begin
                    mode_j = MODE_IGNORE;
                end
                default: begin
                    mode_j = MODE_SKIP;
                end
            endcase
        end
    end

    always_comb begin
        cmd.jv    = jv;
        cmd.jend  = jend;
        cmd.jbyte = jend ? '0 : jbyte;
        cmd.jidx  = jidx;
        cmd.tend  = eol && ((mode_j == MODE_REGULAR) || (mode_j == MODE_QUOTED));
        cmd.fin   = eol;
        cmd.cnt   = count_j;
    end

    assign push = in_accept && (jv || eol);

    always_comb begin
        mode_next       = mode_reg;
        count_next      = count_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        if (in_accept) begin
            if (eol) begin
                mode_next       = MODE_SKIP;
                count_next      = '0;
                held_byte_next  = '0;
                held_valid_next = 1'b0;
            end else begin
                mode_next       = mode_j;
                count_next      = count_j;
                held_byte_next  = swallow ? '0 : in_byte;
                held_valid_next = !swallow;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_SKIP;
            count_reg      <= '0;
            held_byte_reg  <= '0;
            held_valid_reg <= 1'b0;
        end else begin
            mode_reg       <= mode_next;
            count_reg      <= count_next;
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
        end
    end

endmodule

### hw/rtl/ctok_queue.sv
// short entry queue between the front end and the result sequencer
// depends on ctok_pkg

module ctok_queue
    import ctok_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  cmd_t    push_data,
    input  logic    pop,
    output cmd_t    head,
    output q_stat_t stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hw/rtl/ctok_back.sv
// back end: expands each queue entry into one to three result beats
// depends on ctok_pkg

module ctok_back
    import ctok_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              head,
    input  logic              empty,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output kind_t             out_kind,
    output logic [BYTE_W-1:0] out_byte,
    output logic [IDX_W-1:0]  out_idx,
    output logic              out_last
);

    logic [2:0]        done_reg, done_next;
    logic              valid_reg, valid_next;
    kind_t             kind_reg, kind_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              last_reg, last_next;

    logic [2:0]        rem, sel;
    logic              load, sel_last;
    logic [IDX_W-1:0]  end_idx;

    // slot 0 judged byte, slot 1 token closed by line end, slot 2 line done
    assign rem      = {head.fin, head.tend, head.jv} & ~done_reg;
    assign sel      = rem & (~rem + 3'd1);
    assign sel_last = ((rem & ~sel) == '0);
    assign end_idx  = (head.cnt == '0) ? '0 : head.cnt - 1'b1;
    assign load     = !empty && (!valid_reg || out_ready);
    assign pop      = load && sel_last;

    always_comb begin
        done_next  = done_reg;
        valid_next = valid_reg;
        kind_next  = kind_reg;
        byte_next  = byte_reg;
        idx_next   = idx_reg;
        last_next  = last_reg;
        if (load) begin
            valid_next = 1'b1;
            last_next  = sel_last;
            done_next  = sel_last ? '0 : (done_reg | sel);
            if (sel[0]) begin
                kind_next = head.jend ? KIND_END : KIND_BYTE;
                byte_next = head.jbyte;
                idx_next  = head.jidx;
            end else if (sel[1]) begin
                kind_next = KIND_END;
                byte_next = '0;
                idx_next  = end_idx;
            end else begin
                kind_next = KIND_DONE;
                byte_next = '0;
                idx_next  = head.cnt;
            end
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            done_reg  <= done_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        byte_reg <= byte_next;
        idx_reg  <= idx_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_byte  = byte_reg;
    assign out_idx   = idx_reg;
    assign out_last  = last_reg;

endmodule

### tb/tb_command_tokenizer.sv
// self-checking bench for command_tokenizer: directed lines, then random lines over several
// register settings and handshake idling modes, each result beat checked against a predictor
// depends on ctok_pkg and the command_tokenizer rtl

module tb_command_tokenizer;
    import ctok_pkg::*;

    localparam int SETTLE_CYCLES  = 8;     // front end and output register, with margin
    localparam int WATCHDOG_LIMIT = 1000;  // cycles in a row with no beat and no write
    localparam int PRINT_CAP      = 50;

    // one character beat waiting to be sent
    typedef struct packed {
        logic [7:0] chr;
        logic       eol;
    } line_char_t;

    // one result beat as it should come out
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  chr;
        logic [10:0] idx;
        logic        last;
    } token_beat_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_addr  = 1'b0;
    logic [10:0] cfg_wdata = 11'd0;

    line_char_t  pending_chars[$];
    token_beat_t expected_beats[$];

    bit s_busy        = 1'b0;   // a character beat is on s_ and not yet taken
    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int idle_cycles   = 0;
    int mismatches    = 0;
    int result_count  = 0;

    // predictor copy of the registers
    logic        pq_plain_quotes = 1'b0;
    logic [10:0] pq_max_tokens   = MAX_TOKENS_RST;

    // predictor copy of the line state
    mode_t       scan_mode_q = MODE_SKIP;
    logic [7:0]  held_chr    = 8'd0;
    logic        held_ok     = 1'b0;
    logic        swallow     = 1'b0;
    logic [10:0] tok_cnt     = 11'd0;

    // register settings of the random phases, extremes among them
    logic        phase_quotes [0:7] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
    logic [10:0] phase_limit  [0:7] = '{11'd1024, 11'd1, 11'd2, 11'd2047,
                                        11'd5, 11'd1024, 11'd3, 11'd1};

    command_tokenizer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // clock, period 8
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void emit_beat(kind_t k, logic [7:0] c, logic [10:0] i);
        token_beat_t r;
        r.kind = k;
        r.chr  = c;
        r.idx  = i;
        r.last = 1'b0;
        expected_beats.push_back(r);
    endfunction

    // index of the token being built; zero before the first one
    function automatic logic [10:0] open_index();
        return (tok_cnt == 11'd0) ? 11'd0 : tok_cnt - 11'd1;
    endfunction

    function automatic logic is_quote(logic [7:0] c);
        return (c == CH_QUOTE) && !pq_plain_quotes;
    endfunction

    // byte judged between tokens, with one byte of lookahead
    function automatic void judge_between(logic [7:0] c, logic [7:0] nxt);
        logic [10:0] lim;
        lim = (pq_max_tokens > TOKEN_LIMIT_MAX) ? TOKEN_LIMIT_MAX : pq_max_tokens;
        if (c <= CH_SPACE) begin
            return;
        end
        if (c == CH_SLASH && nxt == CH_SLASH) begin
            scan_mode_q = MODE_IGNORE;
        end else if (c == CH_SLASH && nxt == CH_STAR) begin
            scan_mode_q = MODE_COMMENT;
        end else if (tok_cnt >= lim) begin
            // token limit hit: rest of the line is dropped
            scan_mode_q = MODE_IGNORE;
        end else begin
            tok_cnt = tok_cnt + 11'd1;
            if (is_quote(c)) begin
                scan_mode_q = MODE_QUOTED;
            end else begin
                scan_mode_q = MODE_REGULAR;
                emit_beat(KIND_BYTE, c, open_index());
            end
        end
    endfunction

    function automatic void judge_held(logic [7:0] c, logic [7:0] nxt);
        case (scan_mode_q)
            MODE_SKIP: begin
                judge_between(c, nxt);
            end
            MODE_REGULAR: begin
                if (c <= CH_SPACE || is_quote(c) ||
                    (c == CH_SLASH && (nxt == CH_SLASH || nxt == CH_STAR))) begin
                    emit_beat(KIND_END, 8'd0, open_index());
                    scan_mode_q = MODE_SKIP;
                    judge_between(c, nxt);
                end else begin
                    emit_beat(KIND_BYTE, c, open_index());
                end
            end
            MODE_QUOTED: begin
                // only a real quote closes, whatever the quote setting says now
                if (c == CH_QUOTE) begin
                    emit_beat(KIND_END, 8'd0, open_index());
                    scan_mode_q = MODE_SKIP;
                end else begin
                    emit_beat(KIND_BYTE, c, open_index());
                end
            end
            MODE_COMMENT: begin
                // the star of the opener may close it, so slash-star-slash closes at once
                if (c == CH_STAR && nxt == CH_SLASH) begin
                    scan_mode_q = MODE_SKIP;
                    swallow     = 1'b1;
                end
            end
            default: begin
            end
        endcase
    endfunction

    // all result beats caused by one accepted character beat
    function automatic void predict_beat(logic [7:0] c, logic eol_flag);
        int          start;
        token_beat_t r;
        start = expected_beats.size();
        if (eol_flag || c == 8'd0) begin
            if (held_ok) begin
                judge_held(held_chr, 8'd0);
            end
            // open token, or quote never closed, ends with the line
            if (scan_mode_q == MODE_REGULAR || scan_mode_q == MODE_QUOTED) begin
                emit_beat(KIND_END, 8'd0, open_index());
            end
            emit_beat(KIND_DONE, 8'd0, tok_cnt);
            scan_mode_q = MODE_SKIP;
            held_chr    = 8'd0;
            held_ok     = 1'b0;
            swallow     = 1'b0;
            tok_cnt     = 11'd0;
        end else begin
            if (held_ok) begin
                judge_held(held_chr, c);
            end
            if (swallow) begin
                // slash of a comment close goes nowhere
                swallow  = 1'b0;
                held_ok  = 1'b0;
                held_chr = 8'd0;
            end else begin
                held_chr = c;
                held_ok  = 1'b1;
            end
        end
        if (expected_beats.size() > start) begin
            r      = expected_beats.pop_back();
            r.last = 1'b1;
            expected_beats.push_back(r);
        end
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic void push_item(logic [7:0] c, logic e);
        line_char_t it;
        it.chr = c;
        it.eol = e;
        pending_chars.push_back(it);
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            push_item(s[i], 1'b0);
        end
    endfunction

    // token character, leaning on the bytes that steer the scanner
    function automatic logic [7:0] word_char();
        case ($urandom_range(7))
            0: return CH_QUOTE;
            1: return CH_SLASH;
            2: return CH_STAR;
            3: return 8'($urandom_range(8'h21, 8'hFF));
            default: return 8'($urandom_range(8'h21, 8'h7E));
        endcase
    endfunction

    // one random line, mostly well formed; returns the number of beats queued
    function automatic int gen_line();
        int start, pieces, len;
        start = pending_chars.size();
        if ($urandom_range(9) < 2) begin
            // noise: any byte, line end flag now and then
            len = $urandom_range(1, 10);
            for (int k = 0; k < len; k++) begin
                push_item(8'($urandom_range(0, 255)), $urandom_range(7) == 0);
            end
        end else begin
            pieces = $urandom_range(1, 6);
            for (int k = 0; k < pieces; k++) begin
                if ($urandom_range(1) == 1) begin
                    push_item(8'($urandom_range(1, 32)), 1'b0);
                end
                case ($urandom_range(7))
                    0, 1, 2, 7: begin
                        len = $urandom_range(1, 5);
                        for (int j = 0; j < len; j++) begin
                            push_item(word_char(), 1'b0);
                        end
                    end
                    3: begin
                        // quoted token, usually closed
                        push_item(CH_QUOTE, 1'b0);
                        len = $urandom_range(0, 4);
                        for (int j = 0; j < len; j++) begin
                            push_item(8'($urandom_range(1, 255)), 1'b0);
                        end
                        if ($urandom_range(4) != 0) begin
                            push_item(CH_QUOTE, 1'b0);
                        end
                    end
                    4: begin
                        // block comment, usually closed
                        push_text("/*");
                        len = $urandom_range(0, 4);
                        for (int j = 0; j < len; j++) begin
                            push_item($urandom_range(1) ? word_char() : CH_SPACE, 1'b0);
                        end
                        if ($urandom_range(4) != 0) begin
                            push_text("*/");
                        end
                    end
                    5: begin
                        push_text("/*/");
                    end
                    default: begin
                        push_text("//");
                        push_item(word_char(), 1'b0);
                    end
                endcase
            end
        end
        // line end: zero byte or flag over a random byte
        if ($urandom_range(3) == 0) begin
            push_item(8'd0, 1'b0);
        end else begin
            push_item(8'($urandom_range(0, 255)), 1'b1);
        end
        return pending_chars.size() - start;
    endfunction

    // wait until every beat is sent and every result is back, then let the pipe settle
    task automatic drain();
        while (pending_chars.size() != 0 || s_busy || expected_beats.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // register write while idle; the predictor copy changes on the same edge
    task automatic write_reg(logic addr, logic [10:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(posedge aclk);
        if (addr == CFG_PLAIN_QUOTES) begin
            pq_plain_quotes = val[0];
        end else begin
            pq_max_tokens = val;
        end
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP) begin
            $display("mismatch at result %0d: %s got %0h want %0h",
                     result_count, what, got, want);
        end
    endtask

    // ---------------------------------------------------------------- driver

    // inputs change on the falling edge; a new beat only after the previous one is taken
    always @(negedge aclk) begin : char_driver
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
        if (!s_busy) begin
            if (aresetn && pending_chars.size() != 0 &&
                $urandom_range(99) >= tx_idle_pct) begin
                s_tdata  <= pending_chars[0].chr;
                s_tlast  <= pending_chars[0].eol;
                s_tvalid <= 1'b1;
                void'(pending_chars.pop_front());
                s_busy = 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    // prediction first, so a result can never be checked before its cause is known
    always @(posedge aclk) begin : beat_monitor
        token_beat_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_beat(s_tdata, s_tlast);
                s_busy = 1'b0;
            end
            if (m_tvalid && m_tready) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch("result beat with nothing expected", m_tdata, 0);
                end else begin
                    want = expected_beats.pop_front();
                    if (m_tuser !== want.kind) begin
                        report_mismatch("out_kind", m_tuser, want.kind);
                    end
                    if (m_tdata[7:0] !== want.chr) begin
                        report_mismatch("out_byte", m_tdata[7:0], want.chr);
                    end
                    if (m_tdata[18:8] !== want.idx) begin
                        report_mismatch("token_index", m_tdata[18:8], want.idx);
                    end
                    if (m_tdata[23:19] !== 5'd0) begin
                        report_mismatch("tdata pad", m_tdata[23:19], 0);
                    end
                    if (m_tlast !== want.last) begin
                        report_mismatch("last", m_tlast, want.last);
                    end
                end
                result_count++;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
    end

    // watchdog: no beat on either side for too long
    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(negedge aclk);
        end
        $display("tb_command_tokenizer NOT OK");
        $finish;
    end

    // ---------------------------------------------------------------- sequence

    initial begin : test_sequence
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed lines at reset register values, no idling
        // empty line, nonzero byte under the line end flag
        push_item(8'hFF, 1'b1);
        // top byte as a token, a quote that is never closed, zero byte as line end
        push_item(8'hFF, 1'b0);
        push_text("\"q");
        push_item(8'h00, 1'b0);
        // separator, quick comment close, lowest token byte, comment still open at line end
        push_item(CH_SPACE, 1'b0);
        push_text("/*/");
        push_item(8'h21, 1'b0);
        push_text("/*x");
        push_item("z", 1'b1);
        // line comment drops the rest
        push_text("a//b");
        push_item(8'h00, 1'b1);
        drain();

        // token limit of zero: no tokens at all
        write_reg(CFG_MAX_TOKENS, 11'd0);
        push_text("a");
        push_item(8'h00, 1'b1);
        drain();

        // limit above the ceiling, then a write in the middle of a line:
        // the held quote is judged with quotes taken as plain characters
        write_reg(CFG_MAX_TOKENS, 11'd2047);
        push_text("x");
        drain();
        write_reg(CFG_PLAIN_QUOTES, 1'b1);
        push_text("\"");
        push_item(8'h00, 1'b1);
        drain();

        // random lines: each phase its own registers and idling mode
        for (int ph = 0; ph < 8; ph++) begin
            int queued;
            write_reg(CFG_PLAIN_QUOTES, phase_quotes[ph]);
            write_reg(CFG_MAX_TOKENS, phase_limit[ph]);
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 81; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 81; end
                default: begin tx_idle_pct = 34; rx_stall_pct = 34; end
            endcase
            queued = 0;
            while (queued < 7) begin
                queued += gen_line();
            end
            drain();
        end

        if (mismatches == 0 && expected_beats.size() == 0) begin
            $display("tb_command_tokenizer OK");
        end else begin
            $display("tb_command_tokenizer NOT OK");
        end
        $finish;
    end

endmodule
